>>> design/sensor_table_linearizer_defines.svh
// ----------------------------------------------------------------------------
// Sensor table linearizer assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SENSOR_TABLE_LINEARIZER_DEFINES_SVH
`define SENSOR_TABLE_LINEARIZER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define STL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/stl_pkg.sv
// ----------------------------------------------------------------------------
// Sensor table linearizer package
// Types, widths and the calibration breakpoint tables.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

  localparam int X_W     = 12;              // breakpoint count width
  localparam int Y_W     = 12;              // calibrated value width (signed)
  localparam int READ_W  = 13;              // reading width (signed)
  localparam int QUO_W   = 11;              // quotient bits, |reading| < 2048
  localparam int NUM_W   = Y_W + X_W + 1;   // y0*dx + t*dy, signed
  localparam int MAG_W   = NUM_W - 1;       // magnitude of the numerator
  localparam int DCNT_W  = $clog2(QUO_W + 1);
  localparam int RAW_MAX = 4095;

  localparam int SND_N  = 48;
  localparam int TMP_N  = 17;
  localparam int LIT_N  = 11;
  localparam int IDX_W  = $clog2(SND_N);
  localparam int BIT_W  = $clog2(IDX_W);
  localparam int TMP_IW = $clog2(TMP_N);
  localparam int LIT_IW = $clog2(LIT_N);

  localparam logic [READ_W-1:0] READING_MISS = {READ_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_RAW   = 2'd0,
    KIND_SOUND = 2'd1,
    KIND_TEMP  = 2'd2,
    KIND_LIGHT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL0,
    ST_MUL1,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  // Segment found by the search unit
  typedef struct packed {
    logic                  hit;
    logic [X_W-1:0]        t;    // count - x0
    logic [X_W-1:0]        dx;   // x1 - x0
    logic signed [Y_W-1:0] y0;
    logic signed [Y_W-1:0] dy;   // y1 - y0
  } seg_t;

  localparam int SND_X [SND_N] = '{
    0, 3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 14, 16, 17, 19, 23, 28, 34, 41, 50,
    61, 73, 89, 108, 131, 159, 193, 213, 242, 275, 313, 357, 406, 462, 526,
    599, 682, 777, 885, 1007, 1147, 1305, 1486, 1692, 1926, 2193, 2497, 2843
  };
  localparam int SND_Y [SND_N] = '{
    550, 550, 570, 590, 600, 620, 630, 650, 660, 670, 680, 690, 700, 705,
    710, 720, 730, 740, 750, 760, 770, 780, 790, 800, 810, 820, 830, 835,
    840, 850, 860, 870, 880, 890, 900, 910, 920, 930, 940, 950, 960, 970,
    980, 990, 1000, 1010, 1020, 1030
  };
  localparam int TMP_X [TMP_N] = '{
    55, 216, 400, 755, 1384, 1813, 2048, 2289, 2530, 2765, 2985, 3187, 3366,
    3520, 3756, 3907, 4046
  };
  localparam int TMP_Y [TMP_N] = '{
    1500, 1000, 800, 600, 400, 300, 250, 200, 150, 100, 50, 0, -50, -100,
    -200, -300, -500
  };
  localparam int LIT_X [LIT_N] = '{
    0, 410, 819, 1229, 1638, 2048, 2457, 2867, 3276, 3686, 4095
  };
  localparam int LIT_Y [LIT_N] = '{
    0, 20, 40, 60, 110, 160, 230, 320, 440, 620, 1000
  };

  // Breakpoint count; zero past the end of a table
  function automatic logic [X_W-1:0] bp_x(input kind_t kind,
                                          input logic [IDX_W-1:0] idx);
    logic [X_W-1:0] x;
    x = '0;
    case (kind)
      KIND_SOUND: if (idx < IDX_W'(SND_N)) x = X_W'(SND_X[idx]);
      KIND_TEMP:  if (idx < IDX_W'(TMP_N)) x = X_W'(TMP_X[idx[TMP_IW-1:0]]);
      KIND_LIGHT: if (idx < IDX_W'(LIT_N)) x = X_W'(LIT_X[idx[LIT_IW-1:0]]);
      default:    x = '0;
    endcase
    return x;
  endfunction

  // Calibrated value in tenths; zero past the end of a table
  function automatic logic signed [Y_W-1:0] bp_y(input kind_t kind,
                                                 input logic [IDX_W-1:0] idx);
    logic signed [Y_W-1:0] y;
    y = '0;
    case (kind)
      KIND_SOUND: if (idx < IDX_W'(SND_N)) y = Y_W'(SND_Y[idx]);
      KIND_TEMP:  if (idx < IDX_W'(TMP_N)) y = Y_W'(TMP_Y[idx[TMP_IW-1:0]]);
      KIND_LIGHT: if (idx < IDX_W'(LIT_N)) y = Y_W'(LIT_Y[idx[LIT_IW-1:0]]);
      default:    y = '0;
    endcase
    return y;
  endfunction

  // Index of the last breakpoint (inclusive upper bound on the search index)
  function automatic logic [IDX_W-1:0] bp_last(input kind_t kind);
    logic [IDX_W-1:0] n;
    case (kind)
      KIND_SOUND: n = IDX_W'(SND_N - 1);
      KIND_TEMP:  n = IDX_W'(TMP_N - 1);
      KIND_LIGHT: n = IDX_W'(LIT_N - 1);
      default:    n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/sensor_table_linearizer.sv
// ----------------------------------------------------------------------------
// Sensor table linearizer
// Piecewise-linear calibration of a converter count from fixed tables.
// ----------------------------------------------------------------------------
// Each request carries a converter count and a sensor kind (raw, sound,
// temperature, light). Raw passes the count through with in_range set. For a
// calibrated kind the block finds the table segment with lower <= count <
// upper, interpolates between its calibrated values and returns the reading
// in tenths, truncated toward zero; a count outside every segment returns -1
// with in_range clear. One request is worked at a time. A calibrated request
// that hits a segment passes through a 6-step binary search of the table, a
// segment fetch, the multiply states MUL0 and MUL1, the sum state, the serial
// divider and the output state. A calibrated request that misses every
// segment skips the arithmetic, and a raw request goes straight to the
// output state. The result sits in an output register, so the next request
// is accepted while a finished result waits for out_tready; a stalled output
// register holds the following result back until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_table_linearizer #(
  parameter int ADC_BITS = 12          // converter resolution, 10 to 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] adc_count, [15:12] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] action (sensor kind)
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [12:0] reading (signed), [15:13] zero
  output logic             out_tuser   // [0] in_range
);

  localparam int X_W    = stl_pkg::X_W;
  localparam int READ_W = stl_pkg::READ_W;
  localparam int NUM_W  = stl_pkg::NUM_W;
  localparam int QUO_W  = stl_pkg::QUO_W;
  // count width inside the block: at least the table width
  localparam int CNT_W  = (ADC_BITS > X_W) ? ADC_BITS : X_W;
  localparam logic [X_W-1:0] ADC_MASK =
    (ADC_BITS >= X_W) ? {X_W{1'b1}} : X_W'((1 << ADC_BITS) - 1);

  stl_pkg::state_t               state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [READ_W-1:0]             out_val_r, out_val_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [READ_W-1:0]             res_val_r, res_val_nxt;
  logic                          res_hit_r, res_hit_nxt;
  logic signed [NUM_W-1:0]       acc_r, acc_nxt;
  logic signed [NUM_W-1:0]       prod_r, prod_nxt;
  logic                          neg_r, neg_nxt;

  stl_pkg::kind_t                in_kind;
  logic [CNT_W-1:0]              count;
  logic [READ_W-1:0]             raw_val;
  logic                          search_start;
  logic                          search_done;
  stl_pkg::seg_t                 seg;
  logic signed [NUM_W-1:0]       num;
  logic [NUM_W-1:0]              mag_full;
  logic                          div_start;
  logic                          div_done;
  logic [QUO_W-1:0]              quo;
  logic [READ_W-1:0]             quo_ext;

  // Only the low ADC_BITS bits of the count are used, and at most the low X_W bits
  assign in_kind = stl_pkg::kind_t'(in_tuser);
  assign count   = CNT_W'(in_tdata[X_W-1:0] & ADC_MASK);
  // Raw counts above the reading range saturate
  assign raw_val = (count > CNT_W'(stl_pkg::RAW_MAX)) ? READ_W'(stl_pkg::RAW_MAX)
                                                      : READ_W'(count);

  // Numerator y0*dx + t*dy; divide its magnitude, sign goes back afterward
  assign num      = acc_r + prod_r;
  assign mag_full = num[NUM_W-1] ? -num : num;
  assign quo_ext  = {{(READ_W-QUO_W){1'b0}}, quo};

  stl_search #(
    .CNT_W (CNT_W)
  ) u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (search_start),
    .kind  (in_kind),
    .count (count),
    .done  (search_done),
    .seg   (seg)
  );

  stl_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_full[stl_pkg::MAG_W-1:0]),
    .divisor  (seg.dx),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_hit_nxt   = out_hit_r;
    res_val_nxt   = res_val_r;
    res_hit_nxt   = res_hit_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    search_start  = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      stl_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_kind == stl_pkg::KIND_RAW) begin
            res_val_nxt = raw_val;
            res_hit_nxt = 1'b1;
            state_nxt   = stl_pkg::ST_OUT;
          end else begin
            search_start = 1'b1;
            state_nxt    = stl_pkg::ST_SEARCH;
          end
        end
      end
      stl_pkg::ST_SEARCH: begin
        if (search_done) begin
          if (seg.hit) begin
            state_nxt = stl_pkg::ST_MUL0;
          end else begin
            res_val_nxt = stl_pkg::READING_MISS;
            res_hit_nxt = 1'b0;
            state_nxt   = stl_pkg::ST_OUT;
          end
        end
      end
      stl_pkg::ST_MUL0: begin
        acc_nxt   = NUM_W'(seg.y0) * NUM_W'($signed({1'b0, seg.dx}));
        state_nxt = stl_pkg::ST_MUL1;
      end
      stl_pkg::ST_MUL1: begin
        prod_nxt  = NUM_W'($signed({1'b0, seg.t})) * NUM_W'(seg.dy);
        state_nxt = stl_pkg::ST_SUM;
      end
      stl_pkg::ST_SUM: begin
        div_start = 1'b1;
        neg_nxt   = num[NUM_W-1];
        state_nxt = stl_pkg::ST_DIV;
      end
      stl_pkg::ST_DIV: begin
        if (div_done) begin
          res_val_nxt = neg_r ? -quo_ext : quo_ext;  // truncation toward zero
          res_hit_nxt = 1'b1;
          state_nxt   = stl_pkg::ST_OUT;
        end
      end
      stl_pkg::ST_OUT: begin
        // load the output register once it is empty or draining
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_hit_nxt   = res_hit_r;
          state_nxt     = stl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
    out_hit_r <= out_hit_nxt;
    res_val_r <= res_val_nxt;
    res_hit_r <= res_hit_nxt;
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    neg_r     <= neg_nxt;
  end

  assign in_tready  = (state_r == stl_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16-READ_W){1'b0}}, out_val_r};
  assign out_tuser  = out_hit_r;

endmodule

`default_nettype wire

>>> design/stl_search.sv
// ----------------------------------------------------------------------------
// Sensor table linearizer segment search
// Bit-serial binary search of the breakpoint table, one index bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_search #(
  parameter int CNT_W = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire stl_pkg::kind_t       kind,
  input  wire logic [CNT_W-1:0]     count,
  output logic                      done,
  output stl_pkg::seg_t             seg
);

  logic                             busy_r, busy_nxt;
  logic                             fetch_r, fetch_nxt;
  logic                             done_r, done_nxt;
  logic [stl_pkg::BIT_W-1:0]        bit_r, bit_nxt;
  logic [stl_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  stl_pkg::kind_t                   kind_r;
  logic [CNT_W-1:0]                 count_r;
  stl_pkg::seg_t                    seg_r;

  logic [stl_pkg::IDX_W-1:0]        cand;
  logic                             take;
  logic [stl_pkg::X_W-1:0]          x0, x1;
  logic signed [stl_pkg::Y_W-1:0]   y0, y1;
  stl_pkg::seg_t                    seg_nxt;

  // Try setting the current index bit: keep it while the breakpoint <= count
  always_comb begin
    cand = idx_r | (stl_pkg::IDX_W'(1) << bit_r);
    take = (cand <= stl_pkg::bp_last(kind_r)) &&
           (CNT_W'(stl_pkg::bp_x(kind_r, cand)) <= count_r);
  end

  always_comb begin
    x0 = stl_pkg::bp_x(kind_r, idx_r);
    x1 = stl_pkg::bp_x(kind_r, idx_r + stl_pkg::IDX_W'(1));
    y0 = stl_pkg::bp_y(kind_r, idx_r);
    y1 = stl_pkg::bp_y(kind_r, idx_r + stl_pkg::IDX_W'(1));
    seg_nxt.hit = (CNT_W'(x0) <= count_r) && (idx_r != stl_pkg::bp_last(kind_r));
    seg_nxt.t   = stl_pkg::X_W'(count_r - CNT_W'(x0));
    seg_nxt.dx  = x1 - x0;
    seg_nxt.y0  = y0;
    seg_nxt.dy  = y1 - y0;
  end

  always_comb begin
    busy_nxt  = busy_r;
    fetch_nxt = 1'b0;
    done_nxt  = fetch_r;
    bit_nxt   = bit_r;
    idx_nxt   = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = stl_pkg::BIT_W'(stl_pkg::IDX_W - 1);
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (take) begin
        idx_nxt = cand;
      end
      bit_nxt = bit_r - stl_pkg::BIT_W'(1);
      if (bit_r == '0) begin
        busy_nxt  = 1'b0;
        fetch_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fetch_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      fetch_r <= fetch_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    idx_r <= idx_nxt;
    if (start) begin
      kind_r  <= kind;
      count_r <= count;
    end
    if (fetch_r) begin
      seg_r <= seg_nxt;
    end
  end

  assign done = done_r;
  assign seg  = seg_r;

endmodule

`default_nettype wire

>>> design/stl_divider.sv
// ----------------------------------------------------------------------------
// Sensor table linearizer serial divider
// Restoring division, one quotient bit a cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [stl_pkg::MAG_W-1:0]    dividend,
  input  wire logic [stl_pkg::X_W-1:0]      divisor,
  output logic                              done,
  output logic [stl_pkg::QUO_W-1:0]         quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [stl_pkg::DCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [stl_pkg::X_W-1:0]           rem_r, rem_nxt;
  logic [stl_pkg::QUO_W-1:0]         quo_r, quo_nxt;
  logic [stl_pkg::X_W-1:0]           dvs_r;

  logic [stl_pkg::X_W:0]             shifted;
  logic [stl_pkg::X_W+1:0]           diff;
  logic                              ge;

  // Remainder stays below the divisor, so it fits the divisor width
  always_comb begin
    shifted = {rem_r, quo_r[stl_pkg::QUO_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = !diff[stl_pkg::X_W+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = stl_pkg::DCNT_W'(stl_pkg::QUO_W);
      // high part is known to be below the divisor (quotient fits QUO_W bits)
      rem_nxt  = dividend[stl_pkg::QUO_W+stl_pkg::X_W-1:stl_pkg::QUO_W];
      quo_nxt  = dividend[stl_pkg::QUO_W-1:0];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[stl_pkg::X_W-1:0] : shifted[stl_pkg::X_W-1:0];
      quo_nxt = {quo_r[stl_pkg::QUO_W-2:0], ge};
      cnt_nxt = cnt_r - stl_pkg::DCNT_W'(1);
      if (cnt_r == stl_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> design/stl_checker.sv
// ----------------------------------------------------------------------------
// Sensor table linearizer port checker
// Port-level properties of the linearizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_table_linearizer_defines.svh"

module stl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  // stalled result holds
  `STL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // one request in flight: ready drops right after an accept
  `STL_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "request accepted while busy")

  // a miss always reads -1
  `STL_ASSERT_SAME(a_miss_value, out_tvalid && !out_tuser, out_tdata[12:0] == 13'h1FFF, "miss without -1 reading")

  // in-range readings never fall below the lowest table value, -500
  `STL_ASSERT_SAME(a_range, out_tvalid && out_tuser, $signed(out_tdata[12:0]) >= -13'sd500, "reading below table span")

  // padding above the reading stays zero
  `STL_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[15:13] == 3'b000, "nonzero padding bits")

endmodule

bind sensor_table_linearizer stl_checker u_stl_checker (.*);

`default_nettype wire
